>>> rtl/bblur_pkg.sv
// Shared constants, types and helper functions of the 3x3 box blur.
package bblur_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Widths of positions and frame dimensions.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int IROW_W = $clog2(MAX_HEIGHT + 2);

  // Configuration port.
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 13;

  // Pixel and arithmetic widths.
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int RSUM_W = CH_W + 2;
  localparam int SUM_W  = CH_W + 4;
  localparam int X_W    = SUM_W + 1;
  localparam int Y_W    = 12;
  localparam int N_W    = 4;

  // Reciprocals for the divisions by 3 and 9 that remain after the shift.
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = 14;
  localparam int PROD_W      = Y_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    DIV_BY_1,
    DIV_BY_3,
    DIV_BY_9
  } div_e;

  // Red sits in the lowest bits, matching the stream data layout.
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [1:0]     shift;
    div_e           div;
  } plan_t;

  // Control that travels with one item down the pipeline.
  typedef struct packed {
    logic             pix;
    logic             emit;
    logic             old_win;
    logic [COL_W-1:0] col;
    logic [2:0]       col_mask;
    logic [2:0]       row_mask;
    plan_t            plan;
    logic             last;
  } ctl_t;

  function automatic logic [WDIM_W-1:0] eff_width(input logic [FRAME_WIDTH_W-1:0] v);
    logic [WDIM_W-1:0] r;
    if (v == '0) begin
      r = WDIM_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WDIM_W'(MAX_WIDTH);
    end else begin
      r = WDIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [HDIM_W-1:0] eff_height(input logic [FRAME_HEIGHT_W-1:0] v);
    logic [HDIM_W-1:0] r;
    if (v == '0) begin
      r = HDIM_W'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = HDIM_W'(MAX_HEIGHT);
    end else begin
      r = HDIM_W'(v);
    end
    return r;
  endfunction

  // The rounded mean is floor((2*sum + n) / (2*n)); 2*n splits into a shift
  // and a division by 1, 3 or 9.
  function automatic plan_t div_plan(input logic [2:0] row_mask, input logic [2:0] col_mask);
    logic [1:0] rc;
    logic [1:0] cc;
    plan_t      p;
    rc = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
    cc = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);
    p.n = N_W'(rc) * N_W'(cc);
    case (p.n)
      4'd2: begin
        p.shift = 2'd2;
        p.div   = DIV_BY_1;
      end
      4'd3: begin
        p.shift = 2'd1;
        p.div   = DIV_BY_3;
      end
      4'd4: begin
        p.shift = 2'd3;
        p.div   = DIV_BY_1;
      end
      4'd6: begin
        p.shift = 2'd2;
        p.div   = DIV_BY_3;
      end
      4'd9: begin
        p.shift = 2'd1;
        p.div   = DIV_BY_9;
      end
      default: begin
        p.shift = 2'd1;
        p.div   = DIV_BY_1;
      end
    endcase
    return p;
  endfunction

  function automatic logic [CH_W-1:0] chan(input rgb_t p, input int c);
    logic [CH_W-1:0] r;
    case (c)
      0:       r = p.red;
      1:       r = p.green;
      default: r = p.blue;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/box_blur_3x3.sv
// Streaming 3x3 box blur over RGB pixels with edge-clipped rounded means.
// A result passes through the line memory stage, the row-sum, total and reciprocal stages and the output register.
// Throughput: one item per cycle; only output backpressure stalls the pipeline.
// Reset clears positions, pipeline valids and sets the frame to 1024 x 1 pixels.
// The line memory is not cleared; entries that hold no pixel of the frame yet are read but masked out of the sums.
module box_blur_3x3 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bblur_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bblur_pkg::PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
  input  logic [0:0]                       s_axis_tuser,  // req_type
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bblur_pkg::PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue
  output logic                             m_axis_tlast   // frame_last
);
  import bblur_pkg::*;

  // The pipeline runs as one unit: every stage moves when the output register
  // is empty or being drained. A waiting result holds every stage, and a new
  // item is taken in the same cycle as the waiting result leaves.
  logic adv;
  logic out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  // ------------------------------------------------------------------------
  // Frame dimensions and positions. All sequencing is decided at the input
  // transfer, so later stages never feed back into control.
  // ------------------------------------------------------------------------
  logic [WDIM_W-1:0] w_q, w_d;
  logic [HDIM_W-1:0] h_q, h_d;
  logic [COL_W-1:0]  icol_q, icol_d;
  logic [IROW_W-1:0] irow_q, irow_d;
  logic [COL_W-1:0]  ocol_q, ocol_d;
  logic [ROW_W-1:0]  orow_q, orow_d;

  logic in_fire;
  logic is_pix;
  logic inputs_done;
  logic act;
  logic icol_end;
  logic ocol_end;
  logic ci0;
  ctl_t ctl;

  assign in_fire     = s_axis_tvalid && adv;
  assign is_pix      = (s_axis_tuser == REQ_PIXEL);
  assign inputs_done = (irow_q >= IROW_W'(h_q));
  // A pixel after all pixels of the frame, or a drain before them, is
  // consumed without any effect.
  assign act         = in_fire && (is_pix != inputs_done);
  assign icol_end    = (WDIM_W'(icol_q) == w_q - WDIM_W'(1));
  assign ocol_end    = (WDIM_W'(ocol_q) == w_q - WDIM_W'(1));
  assign ci0         = (icol_q == '0);

  always_comb begin
    ctl.pix     = is_pix;
    // An output is due once the input is one row and one pixel ahead.
    ctl.emit    = (irow_q >= IROW_W'(2)) || ((irow_q == IROW_W'(1)) && !ci0);
    // At the first column of a row the finished pixel is the last one of the
    // previous row, so the mean uses the window before the new column enters.
    ctl.old_win = ci0;
    ctl.col     = icol_q;
    // Bit i marks window column i as lying inside the image.
    ctl.col_mask[0] = ci0 ? (w_q >= WDIM_W'(3)) : (icol_q >= COL_W'(2));
    ctl.col_mask[1] = ci0 ? (w_q >= WDIM_W'(2)) : 1'b1;
    ctl.col_mask[2] = 1'b1;
    // Bit j marks window row j (image row orow - 1 + j) as inside the image.
    ctl.row_mask[0] = (orow_q != '0);
    ctl.row_mask[1] = 1'b1;
    ctl.row_mask[2] = (HDIM_W'(orow_q) != h_q - HDIM_W'(1));
    ctl.plan        = div_plan(ctl.row_mask, ctl.col_mask);
    ctl.last        = (HDIM_W'(orow_q) == h_q - HDIM_W'(1)) && ocol_end;
  end

  always_comb begin
    w_d    = w_q;
    h_d    = h_q;
    icol_d = icol_q;
    irow_d = irow_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (cfg_valid_i) begin
      // Any register write starts a new frame.
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_WIDTH:  w_d = eff_width(cfg_data_i[FRAME_WIDTH_W-1:0]);
        REG_FRAME_HEIGHT: h_d = eff_height(cfg_data_i[FRAME_HEIGHT_W-1:0]);
      endcase
      icol_d = '0;
      irow_d = '0;
      ocol_d = '0;
      orow_d = '0;
    end else if (act) begin
      if (ctl.emit && ctl.last) begin
        // Final output of the frame: the next pixel opens a new frame.
        icol_d = '0;
        irow_d = '0;
        ocol_d = '0;
        orow_d = '0;
      end else begin
        if (icol_end) begin
          icol_d = '0;
          irow_d = irow_q + IROW_W'(1);
        end else begin
          icol_d = icol_q + COL_W'(1);
        end
        if (ctl.emit) begin
          if (ocol_end) begin
            ocol_d = '0;
            orow_d = orow_q + ROW_W'(1);
          end else begin
            ocol_d = ocol_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WDIM_W'(MAX_WIDTH);
      h_q    <= HDIM_W'(1);
      icol_q <= '0;
      irow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      w_q    <= w_d;
      h_q    <= h_d;
      icol_q <= icol_d;
      irow_q <= irow_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 1: line memory. One entry per column holds the pixels two rows
  // back (upper half) and one row back (lower half). The read is issued at
  // the input transfer; the write-back happens when the item leaves stage 1.
  // ------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] byp_data_q;
  logic               byp_vld_q;
  logic               s1_vld_q;
  ctl_t               s1_q;
  rgb_t               s1_px_q;

  logic [2*PIX_W-1:0] line_eff;
  logic [2*PIX_W-1:0] wr_data;
  logic               wr_en;
  rgb_t               upper_eff;
  rgb_t               middle_eff;

  // With a one pixel wide frame, consecutive items hit the same entry; the
  // read then misses the write of the item just ahead, which is forwarded.
  assign line_eff   = byp_vld_q ? byp_data_q : rd_q;
  assign upper_eff  = rgb_t'(line_eff[2*PIX_W-1:PIX_W]);
  assign middle_eff = rgb_t'(line_eff[PIX_W-1:0]);
  assign wr_data    = {middle_eff, s1_px_q};
  assign wr_en      = adv && s1_vld_q && s1_q.pix;

  always_ff @(posedge clk_i) begin
    if (act) begin
      rd_q <= line_mem[icol_q];
    end
    if (wr_en) begin
      line_mem[s1_q.col] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      s1_q       <= ctl;
      s1_px_q    <= is_pix ? rgb_t'(s_axis_tdata) : '0;
      byp_vld_q  <= s1_vld_q && s1_q.pix && (s1_q.col == icol_q);
      byp_data_q <= wr_data;
    end
  end

  // ------------------------------------------------------------------------
  // Window of the last three column vectors, indexed [row][column]. Column 2
  // is the newest; rows are two back, one back and the current input row.
  // ------------------------------------------------------------------------
  rgb_t win_q [3][3];
  rgb_t win_d [3][3];
  rgb_t src   [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      win_d[j][0] = win_q[j][1];
      win_d[j][1] = win_q[j][2];
    end
    win_d[0][2] = upper_eff;
    win_d[1][2] = middle_eff;
    win_d[2][2] = s1_px_q;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        src[j][i] = s1_q.old_win ? win_q[j][i] : win_d[j][i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      win_q <= win_d;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 2: per-row sums of the columns that lie inside the image.
  // ------------------------------------------------------------------------
  logic              s2_vld_q;
  ctl_t              s2_q;
  logic [RSUM_W-1:0] rsum_q [3][3];  // [row][channel]
  logic [RSUM_W-1:0] rsum_d [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < 3; c++) begin
        rsum_d[j][c] = '0;
        for (int i = 0; i < 3; i++) begin
          if (s1_q.col_mask[i]) begin
            rsum_d[j][c] = rsum_d[j][c] + RSUM_W'(chan(src[j][i], c));
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q   <= s1_q;
      rsum_q <= rsum_d;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 3: total over the rows inside the image, rounding bias and the
  // power-of-two part of the division.
  // ------------------------------------------------------------------------
  logic           s3_vld_q;
  ctl_t           s3_q;
  logic [Y_W-1:0] y_q [3];
  logic [Y_W-1:0] y_d [3];
  logic [SUM_W-1:0] tot;
  logic [X_W-1:0]   xval;

  always_comb begin
    tot  = '0;
    xval = '0;
    for (int c = 0; c < 3; c++) begin
      tot = '0;
      for (int j = 0; j < 3; j++) begin
        if (s2_q.row_mask[j]) begin
          tot = tot + SUM_W'(rsum_q[j][c]);
        end
      end
      xval   = {tot, 1'b0} + X_W'(s2_q.plan.n);
      y_d[c] = Y_W'(xval >> s2_q.plan.shift);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q <= s2_q;
      y_q  <= y_d;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 4: division by 3 or 9 as a multiplication by the reciprocal.
  // ------------------------------------------------------------------------
  logic              s4_vld_q;
  ctl_t              s4_q;
  logic [Y_W-1:0]    y4_q    [3];
  logic [PROD_W-1:0] prod_q  [3];
  logic [RECIP_W-1:0] recip;

  assign recip = (s3_q.plan.div == DIV_BY_9) ? RECIP_9 : RECIP_3;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q <= s3_q;
      y4_q <= y_q;
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= PROD_W'(y_q[c]) * PROD_W'(recip);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------------
  rgb_t out_px_q;
  rgb_t out_px_d;
  logic out_last_q;
  logic [CH_W-1:0] q_ch [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_ch[c] = (s4_q.plan.div == DIV_BY_1) ? y4_q[c][CH_W-1:0]
                                            : prod_q[c][RECIP_SHIFT +: CH_W];
    end
    out_px_d.red   = q_ch[0];
    out_px_d.green = q_ch[1];
    out_px_d.blue  = q_ch[2];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_px_q   <= out_px_d;
      out_last_q <= s4_q.last;
    end
  end

  // Valid bits of the pipeline. Stage 1 carries every effective item since
  // the window shifts for each of them; later stages carry only outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= act;
      s2_vld_q  <= s1_vld_q && s1_q.emit;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_px_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> bench/box_blur_3x3_check.sv
`timescale 1ns / 1ps
// Checker for the 3x3 box blur: predicts the blurred pixels from the observed transfers and compares them.
module box_blur_3x3_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [bblur_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [bblur_pkg::PIX_W-1:0]      s_tdata_i,
  input  logic [0:0]                       s_tuser_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [bblur_pkg::PIX_W-1:0]      m_tdata_i,
  input  logic                             m_tlast_i,
  output int                               pending_o,
  output int                               errors_o
);
  import bblur_pkg::*;

  typedef struct packed {
    rgb_t pix;
    logic last;
  } blurred_px_t;

  logic [FRAME_WIDTH_W-1:0]  width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;
  rgb_t                      upper_line [MAX_WIDTH];
  rgb_t                      middle_line [MAX_WIDTH];
  rgb_t                      win [3][3];
  int                        in_col, in_row, out_col, out_row;
  int                        result_idx;
  blurred_px_t               blurred_q [$];

  function automatic int clip_dim(input int v, input int lim);
    int r;
    r = (v == 0) ? 1 : ((v > lim) ? lim : v);
    return r;
  endfunction

  // Window column i is image column colbase + i, window row j is image row ro - 1 + j.
  function automatic rgb_t neighbourhood_mean(input int ro, input int colbase,
                                               input int w, input int h);
    int   sum_r, sum_g, sum_b, n, r, c;
    rgb_t m;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (int j = 0; j < 3; j++) begin
      r = ro - 1 + j;
      for (int i = 0; i < 3; i++) begin
        c = colbase + i;
        if (r >= 0 && r < h && c >= 0 && c < w) begin
          sum_r += win[j][i].red;
          sum_g += win[j][i].green;
          sum_b += win[j][i].blue;
          n++;
        end
      end
    end
    m = '0;
    if (n != 0) begin
      m.red   = CH_W'((2 * sum_r + n) / (2 * n));
      m.green = CH_W'((2 * sum_g + n) / (2 * n));
      m.blue  = CH_W'((2 * sum_b + n) / (2 * n));
    end
    return m;
  endfunction

  task automatic restart_frame();
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        win[j][i] = '0;
      end
    end
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic predict_blur(input req_e kind, input rgb_t px);
    int          w, h, col;
    bit          is_pix, all_in, emit;
    rgb_t        res;
    blurred_px_t e;
    w      = clip_dim(int'(width_reg), MAX_WIDTH);
    h      = clip_dim(int'(height_reg), MAX_HEIGHT);
    is_pix = (kind == REQ_PIXEL);
    all_in = (in_row >= h);
    // A drain while pixels are still due, or a pixel while draining, is dropped.
    if (is_pix == all_in) return;
    col  = in_col;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    res  = '0;
    // At a row start the window still holds the end of the previous row.
    if (emit && in_col == 0) res = neighbourhood_mean(out_row, w - 3, w, h);
    for (int j = 0; j < 3; j++) begin
      win[j][0] = win[j][1];
      win[j][1] = win[j][2];
    end
    win[0][2] = upper_line[col];
    win[1][2] = middle_line[col];
    win[2][2] = is_pix ? px : rgb_t'('0);
    if (is_pix) begin
      upper_line[col]  = middle_line[col];
      middle_line[col] = px;
    end
    if (emit && in_col != 0) res = neighbourhood_mean(out_row, in_col - 2, w, h);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (emit) begin
      e.pix  = res;
      e.last = (out_row == h - 1) && (out_col == w - 1);
      blurred_q.push_back(e);
      if (e.last) begin
        restart_frame();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t result %0d: %s", $time, result_idx, what);
    errors_o++;
  endtask

  task automatic compare_blur(input rgb_t got, input logic got_last);
    blurred_px_t e;
    if (blurred_q.size() == 0) begin
      report_mismatch("output transfer with no pixel expected");
    end else begin
      e = blurred_q.pop_front();
      if (got.red !== e.pix.red)
        report_mismatch($sformatf("red %0h, expected %0h", got.red, e.pix.red));
      if (got.green !== e.pix.green)
        report_mismatch($sformatf("green %0h, expected %0h", got.green, e.pix.green));
      if (got.blue !== e.pix.blue)
        report_mismatch($sformatf("blue %0h, expected %0h", got.blue, e.pix.blue));
      if (got_last !== e.last)
        report_mismatch($sformatf("tlast %b, expected %b", got_last, e.last));
    end
    result_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = FRAME_WIDTH_W'(MAX_WIDTH);
      height_reg = FRAME_HEIGHT_W'(1);
      restart_frame();
      blurred_q.delete();
      result_idx = 0;
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_FRAME_WIDTH:  width_reg = cfg_data_i[FRAME_WIDTH_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data_i[FRAME_HEIGHT_W-1:0];
          default:          ;
        endcase
        restart_frame();
      end
      if (s_tvalid_i && s_tready_i) predict_blur(req_e'(s_tuser_i), rgb_t'(s_tdata_i));
      if (m_tvalid_i && m_tready_i) compare_blur(rgb_t'(m_tdata_i), m_tlast_i);
      pending_o = blurred_q.size();
    end
  end

endmodule

>>> bench/box_blur_3x3_test.sv
`timescale 1ns / 1ps
// Testbench top for the 3x3 box blur: clock, reset, configuration and pixel stimulus, verdict.
module box_blur_3x3_test;
  import bblur_pkg::*;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_ADDR_W-1:0]     cfg_addr_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [PIX_W-1:0]          s_axis_tdata;   // in_red, in_green, in_blue
  logic [0:0]                s_axis_tuser;   // req_type
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [PIX_W-1:0]          m_axis_tdata;   // out_red, out_green, out_blue
  logic                      m_axis_tlast;   // frame_last

  int                        pending;
  int                        errors;

  // Knobs shared between the sender, the receiver and the sequence below.
  int                        send_idle_pct;
  int                        recv_stall_pct;
  int                        hold_cycles;
  int                        counted_items;
  bit                        frame_open;

  // Raw register values as last written; the frame shape follows from them.
  logic [FRAME_WIDTH_W-1:0]  width_set;
  logic [FRAME_HEIGHT_W-1:0] height_set;

  box_blur_3x3 u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  box_blur_3x3_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #5_000_000;
    $display("box_blur_3x3 verification failed");
    $finish;
  end

  // Output side. A hold request parks tready low while the hold count, decremented
  // here, is nonzero, so the pipeline fills up and the block has to stall its input.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Channels are pushed toward the extremes now and then so every bit toggles
  // and the rounding sees both saturated and mixed sums.
  function automatic rgb_t random_pixel();
    rgb_t p;
    p = rgb_t'(PIX_W'($urandom));
    case ($urandom_range(7))
      0:       p.red = '0;
      1:       p.red = '1;
      default: ;
    endcase
    case ($urandom_range(7))
      0:       p.green = '0;
      1:       p.green = '1;
      default: ;
    endcase
    case ($urandom_range(7))
      0:       p.blue = '0;
      1:       p.blue = '1;
      default: ;
    endcase
    return p;
  endfunction

  // Effective frame shape: zero counts as one, anything above the maximum saturates.
  function automatic int frame_cols();
    return (width_set == '0) ? 1 : ((int'(width_set) > MAX_WIDTH) ? MAX_WIDTH : int'(width_set));
  endfunction

  function automatic int frame_rows();
    return (height_set == '0) ? 1 :
           ((int'(height_set) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_set));
  endfunction

  // One input transfer. Random gaps come first, then tvalid stays up until the
  // block takes the item; tvalid is left high so back-to-back items need no bubble.
  task automatic send_item(input req_e kind, input rgb_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Waits until every predicted pixel has come out, then lets the pipeline
  // settle, since drains and dropped items leave no result to wait for.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  width_set = val[FRAME_WIDTH_W-1:0];
      REG_FRAME_HEIGHT: height_set = val[FRAME_HEIGHT_W-1:0];
      default:          ;
    endcase
    frame_open = 1'b0;
  endtask

  // One frame: all pixels in raster order, then width + 1 drains to flush the
  // outputs that trail by a row and a pixel. Dropped items (a drain while pixels
  // are due, a pixel while draining) are mixed in as noise. A cut frame stops
  // early and must be closed by a register write.
  task automatic run_frame(input int noise_pct, input bit cut);
    int w, h, npix, total, stop_at;
    w       = frame_cols();
    h       = frame_rows();
    npix    = w * h;
    total   = npix + w + 1;
    stop_at = cut ? $urandom_range(total - 1, 1) : total;
    for (int k = 0; k < stop_at; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        if (k < npix) send_item(REQ_DRAIN, random_pixel());
        else send_item(REQ_PIXEL, random_pixel());
      end
      if (k < npix) send_item(REQ_PIXEL, random_pixel());
      else send_item(REQ_DRAIN, random_pixel());
      counted_items++;
    end
    // A drain right after the drain that closes the frame finds a fresh frame and is dropped.
    if (!cut && $urandom_range(99) < noise_pct) send_item(REQ_DRAIN, random_pixel());
    frame_open = cut;
  endtask

  // Mostly small frames so that many frame edges are crossed; some wider rows.
  task automatic random_shape();
    int sel, r;
    sel = $urandom_range(2);
    if (sel != 1) begin
      r = $urandom_range(19);
      if (r == 0) write_reg(REG_FRAME_WIDTH, '0);
      else if (r < 3) write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(40, 11)));
      else write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(10, 1)));
    end
    if (sel != 0) begin
      r = $urandom_range(19);
      if (r == 0) write_reg(REG_FRAME_HEIGHT, '0);
      else if (r == 1) write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(12, 7)));
      else write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(6, 1)));
    end
  endtask

  task automatic random_frames(input int idle_pct, input int stall_pct, input int quota);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = counted_items;
    while (counted_items - start < quota) begin
      if (frame_open || $urandom_range(2) == 0) random_shape();
      run_frame(5, $urandom_range(9) == 0);
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= REG_FRAME_WIDTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_PIXEL;
    width_set      = FRAME_WIDTH_W'(MAX_WIDTH);
    height_set     = FRAME_HEIGHT_W'(1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    frame_open     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The shape left by reset is one full-width row; a short run of its pixels
    // is cut off by the register write that follows.
    repeat (24) send_item(REQ_PIXEL, random_pixel());

    // Directed 3x2 frame. Black, white and mixed pixels make the edge and
    // corner means land on rounding halves.
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    send_item(REQ_DRAIN, '1);                  // nothing in yet: dropped
    for (int k = 0; k < 6; k++) begin
      send_item(REQ_PIXEL, rgb_t'((k % 3 == 0) ? 24'hFFFFFF :
                                  ((k % 3 == 1) ? 24'h000000 : 24'h01FF80)));
    end
    send_item(REQ_DRAIN, '0);
    send_item(REQ_PIXEL, '1);                  // pixel while draining: dropped
    repeat (3) send_item(REQ_DRAIN, '0);
    send_item(REQ_DRAIN, '0);                  // frame already closed: dropped

    // Zero registers count as one: a single pixel whose first drain emits nothing.
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    send_item(REQ_PIXEL, '1);
    repeat (2) send_item(REQ_DRAIN, '0);
    // The next pixel opens a new frame without a register write.
    send_item(REQ_PIXEL, rgb_t'(24'h80017F));
    repeat (2) send_item(REQ_DRAIN, '0);

    // Largest shapes, each cut short by the next register write. All-ones data
    // also checks that the unused upper bits of the width write are ignored and
    // that both registers saturate.
    write_reg(REG_FRAME_WIDTH, '1);
    repeat (40) send_item(REQ_PIXEL, random_pixel());
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '1);
    repeat (60) send_item(REQ_PIXEL, random_pixel());

    // Backpressure: the receiver holds off for a long stretch while the sender
    // keeps offering pixels, so the pipeline fills and the input stalls.
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(16));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(6));
    hold_cycles = 300;
    run_frame(0, 1'b0);

    // Random frames under each idling mix.
    random_frames(0, 0, 120);
    random_frames(66, 0, 120);
    random_frames(0, 66, 120);
    random_frames(26, 26, 120);

    // Drain everything, then give the pipeline time to show any stray output.
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("box_blur_3x3 verification clean");
    end else begin
      $display("box_blur_3x3 verification failed");
    end
    $finish;
  end

endmodule

>>> box_blur_3x3.f
rtl/bblur_pkg.sv
rtl/box_blur_3x3.sv
bench/box_blur_3x3_check.sv
bench/box_blur_3x3_test.sv
